// File: rtl/core/rcfi_pkg.sv
// ----------------------------------------------------------------------------
// rcfi_pkg
// Shared types and constants for the ray / cube face intersection unit.
// ----------------------------------------------------------------------------
package rcfi_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int EPSILON_LSB_DEF = 1;

    localparam int NUM_FACES  = 6;
    localparam int QUOT_W     = 31;
    localparam int DIV_STAGES = QUOT_W + 1;
    localparam int CMP_W      = 64;
    localparam int COORD_W    = 32;
    localparam int DIFF_W     = COORD_W + 2;
    localparam int PT_W       = 66;

    localparam int CFG_IDX_W  = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CORNER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE     = 2'd3;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic [30:0]        nearest_in;
    } t_ray_in;

    typedef struct packed {
        logic        hit;
        logic [30:0] nearest_out;
        logic [2:0]  face;
    } t_ray_out;

endpackage

// File: rtl/core/rcfi_div_lane.sv
// ----------------------------------------------------------------------------
// rcfi_div_lane
// Pipelined restoring divider, one quotient bit per stage, with range check.
// ----------------------------------------------------------------------------
module rcfi_div_lane #(
    parameter int NUM_W = rcfi_pkg::DIFF_W + rcfi_pkg::FRAC_BITS_DEF
) (
    input  logic                              i_clk,
    input  logic [NUM_W-1:0]                  i_num,
    input  logic [rcfi_pkg::COORD_W-1:0]      i_den,
    input  logic                              i_pos,
    output logic [rcfi_pkg::QUOT_W-1:0]       o_quot,
    output logic                              o_ok
);

    localparam int NS = rcfi_pkg::DIV_STAGES;
    localparam int CW = rcfi_pkg::CMP_W;
    localparam int QW = rcfi_pkg::QUOT_W;

    logic [CW-1:0]                   r_rem  [NS];
    logic [rcfi_pkg::COORD_W-1:0]    r_den  [NS];
    logic [QW-1:0]                   r_quot [NS];
    logic                            r_ok   [NS];

    // range check: quotient of 2^31 or more can never win
    always_ff @(posedge i_clk) begin
        r_rem[0]  <= CW'(i_num);
        r_den[0]  <= i_den;
        r_quot[0] <= '0;
        r_ok[0]   <= i_pos && (CW'(i_num) < (CW'(i_den) << QW));
    end

    for (genvar s = 1; s < NS; s++) begin : g_stage
        localparam int BIT = QW - s;
        logic [CW-1:0] den_sh;
        logic          ge;
        logic [CW-1:0] n_rem;
        logic [QW-1:0] n_quot;

        always_comb begin
            den_sh = CW'(r_den[s-1]) << BIT;
            ge     = r_rem[s-1] >= den_sh;
            n_rem  = ge ? (r_rem[s-1] - den_sh) : r_rem[s-1];
            n_quot = r_quot[s-1];
            n_quot[BIT] = ge;
        end

        always_ff @(posedge i_clk) begin
            r_rem[s]  <= n_rem;
            r_den[s]  <= r_den[s-1];
            r_quot[s] <= n_quot;
            r_ok[s]   <= r_ok[s-1];
        end
    end

    assign o_quot = r_quot[NS-1];
    assign o_ok   = r_ok[NS-1] && (r_quot[NS-1] != '0);

endmodule

// File: rtl/core/rcfi_face_chk.sv
// ----------------------------------------------------------------------------
// rcfi_face_chk
// Hit point of one face on its two cross axes and the widened box test.
// ----------------------------------------------------------------------------
module rcfi_face_chk #(
    parameter int FRAC_BITS   = rcfi_pkg::FRAC_BITS_DEF,
    parameter int EPSILON_LSB = rcfi_pkg::EPSILON_LSB_DEF
) (
    input  logic                          i_clk,
    input  logic [rcfi_pkg::QUOT_W-1:0]   i_t,
    input  logic                          i_ok,
    input  logic signed [31:0]            i_org_a,
    input  logic signed [31:0]            i_dir_a,
    input  logic signed [31:0]            i_lo_a,
    input  logic signed [31:0]            i_org_b,
    input  logic signed [31:0]            i_dir_b,
    input  logic signed [31:0]            i_lo_b,
    input  logic [30:0]                   i_edge,
    output logic [rcfi_pkg::QUOT_W-1:0]   o_t,
    output logic                          o_ok
);

    localparam int PW = rcfi_pkg::PT_W;

    logic signed [31:0] t_s;
    logic signed [63:0] n_prod_a, n_prod_b;
    logic signed [63:0] r_prod_a, r_prod_b;
    logic signed [31:0] r_org_a, r_org_b;
    logic [rcfi_pkg::QUOT_W-1:0] r_t1;
    logic               r_ok1;

    assign t_s = $signed({1'b0, i_t});

    always_comb begin
        n_prod_a = t_s * i_dir_a;
        n_prod_b = t_s * i_dir_b;
    end

    always_ff @(posedge i_clk) begin
        r_prod_a <= n_prod_a;
        r_prod_b <= n_prod_b;
        r_org_a  <= i_org_a;
        r_org_b  <= i_org_b;
        r_t1     <= i_t;
        r_ok1    <= i_ok;
    end

    // scale back with truncation toward zero, then test against widened box
    logic signed [63:0] adj_a, adj_b;
    logic signed [PW-1:0] p_a, p_b, lo_a_min, lo_b_min, hi_a, hi_b, eps, edge_s;
    logic in_a, in_b;

    always_comb begin
        adj_a    = (r_prod_a + (r_prod_a[63] ? 64'((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0))
                   >>> FRAC_BITS;
        adj_b    = (r_prod_b + (r_prod_b[63] ? 64'((64'sd1 <<< FRAC_BITS) - 64'sd1) : 64'sd0))
                   >>> FRAC_BITS;
        p_a      = PW'(r_org_a) + PW'(adj_a);
        p_b      = PW'(r_org_b) + PW'(adj_b);
        eps      = PW'(EPSILON_LSB);
        edge_s   = PW'($signed({1'b0, i_edge}));
        lo_a_min = PW'(i_lo_a) - eps;
        lo_b_min = PW'(i_lo_b) - eps;
        hi_a     = PW'(i_lo_a) + edge_s + eps;
        hi_b     = PW'(i_lo_b) + edge_s + eps;
        in_a     = (p_a >= lo_a_min) && (p_a <= hi_a);
        in_b     = (p_b >= lo_b_min) && (p_b <= hi_b);
    end

    always_ff @(posedge i_clk) begin
        o_t  <= r_t1;
        o_ok <= r_ok1 && in_a && in_b;
    end

endmodule

// File: rtl/core/ray_cube_face_intersect_unit.sv
// ----------------------------------------------------------------------------
// ray_cube_face_intersect_unit
// Ray against axis-aligned cube: six face divisions in parallel lanes, hit
// point box tests, then nearest-face selection with earlier face on ties.
// ----------------------------------------------------------------------------
// throughput: one transaction per cycle, busy is never raised
// latency is set by the input register, the 32-stage divider lanes plus prep, check and select
// reset: synchronous active low, clears valid bits and loads cube defaults
// results are strobed for one cycle, the receiver cannot stall
module ray_cube_face_intersect_unit #(
    parameter int FRAC_BITS   = rcfi_pkg::FRAC_BITS_DEF,
    parameter int EPSILON_LSB = rcfi_pkg::EPSILON_LSB_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  rcfi_pkg::t_ray_in                  i_ray,
    output logic                               o_valid,
    output rcfi_pkg::t_ray_out                 o_res,
    input  logic                               i_cfg_we,
    input  logic [rcfi_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [31:0]                        i_cfg_data
);

    localparam int NF    = rcfi_pkg::NUM_FACES;
    localparam int NS    = rcfi_pkg::DIV_STAGES;
    localparam int DLY   = NS + 3;
    localparam int NUM_W = rcfi_pkg::DIFF_W + FRAC_BITS;
    localparam int DW    = rcfi_pkg::DIFF_W;
    localparam int QW    = rcfi_pkg::QUOT_W;

    // configuration
    logic signed [31:0] r_corner_x, r_corner_y, r_corner_z;
    logic [30:0]        r_edge;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_corner_x <= '0;
            r_corner_y <= '0;
            r_corner_z <= '0;
            r_edge     <= 31'(32'd1 << FRAC_BITS);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rcfi_pkg::CFG_CORNER_X: r_corner_x <= i_cfg_data;
                rcfi_pkg::CFG_CORNER_Y: r_corner_y <= i_cfg_data;
                rcfi_pkg::CFG_CORNER_Z: r_corner_z <= i_cfg_data;
                rcfi_pkg::CFG_EDGE:     r_edge     <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // input register
    rcfi_pkg::t_ray_in r_s1;
    logic              r_s1_vld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else begin
            r_s1_vld <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1 <= i_ray;
    end

    // ray delay line alongside the lanes
    rcfi_pkg::t_ray_in r_pipe [DLY];
    logic              r_vld  [DLY];

    always_ff @(posedge i_clk) begin
        r_pipe[0] <= r_s1;
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r_s1_vld;
        end
    end

    for (genvar k = 1; k < DLY; k++) begin : g_dly
        always_ff @(posedge i_clk) begin
            r_pipe[k] <= r_pipe[k-1];
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    logic signed [31:0] s1_org [3];
    logic signed [31:0] s1_dir [3];
    logic signed [31:0] lo     [3];
    logic signed [31:0] ck_org [3];
    logic signed [31:0] ck_dir [3];

    assign s1_org[0] = r_s1.origin_x;
    assign s1_org[1] = r_s1.origin_y;
    assign s1_org[2] = r_s1.origin_z;
    assign s1_dir[0] = r_s1.dir_x;
    assign s1_dir[1] = r_s1.dir_y;
    assign s1_dir[2] = r_s1.dir_z;
    assign lo[0]     = r_corner_x;
    assign lo[1]     = r_corner_y;
    assign lo[2]     = r_corner_z;
    assign ck_org[0] = r_pipe[NS].origin_x;
    assign ck_org[1] = r_pipe[NS].origin_y;
    assign ck_org[2] = r_pipe[NS].origin_z;
    assign ck_dir[0] = r_pipe[NS].dir_x;
    assign ck_dir[1] = r_pipe[NS].dir_y;
    assign ck_dir[2] = r_pipe[NS].dir_z;

    logic [QW-1:0] face_t  [NF];
    logic          face_ok [NF];

    for (genvar f = 0; f < NF; f++) begin : g_face
        localparam int AX = 2 - f / 2;
        localparam int A1 = (AX + 1) % 3;
        localparam int A2 = (AX + 2) % 3;
        localparam bit HI = (f % 2) == 0;

        logic signed [DW-1:0] plane, diff;
        logic [DW-1:0]        mag;
        logic [NUM_W-1:0]     n_num, r_num;
        logic [31:0]          n_den, r_den;
        logic                 n_pos, r_pos;
        logic [QW-1:0]        div_q;
        logic                 div_ok;

        // plane offset, magnitudes and sign agreement
        always_comb begin
            plane = DW'(lo[AX]) + (HI ? DW'($signed({1'b0, r_edge})) : DW'(0));
            diff  = plane - DW'(s1_org[AX]);
            mag   = diff[DW-1] ? DW'(-diff) : DW'(diff);
            n_num = NUM_W'(mag) << FRAC_BITS;
            n_den = s1_dir[AX][31] ? 32'(-s1_dir[AX]) : 32'(s1_dir[AX]);
            n_pos = (s1_dir[AX] != '0) && (diff != '0) && (diff[DW-1] == s1_dir[AX][31]);
        end

        always_ff @(posedge i_clk) begin
            r_num <= n_num;
            r_den <= n_den;
            r_pos <= n_pos;
        end

        rcfi_div_lane #(
            .NUM_W (NUM_W)
        ) u_div (
            .i_clk  (i_clk),
            .i_num  (r_num),
            .i_den  (r_den),
            .i_pos  (r_pos),
            .o_quot (div_q),
            .o_ok   (div_ok)
        );

        rcfi_face_chk #(
            .FRAC_BITS   (FRAC_BITS),
            .EPSILON_LSB (EPSILON_LSB)
        ) u_chk (
            .i_clk   (i_clk),
            .i_t     (div_q),
            .i_ok    (div_ok),
            .i_org_a (ck_org[A1]),
            .i_dir_a (ck_dir[A1]),
            .i_lo_a  (lo[A1]),
            .i_org_b (ck_org[A2]),
            .i_dir_b (ck_dir[A2]),
            .i_lo_b  (lo[A2]),
            .i_edge  (r_edge),
            .o_t     (face_t[f]),
            .o_ok    (face_ok[f])
        );
    end

    // nearest face, earlier face wins a tie
    rcfi_pkg::t_ray_out n_out, r_out;
    logic               r_out_vld;

    always_comb begin
        n_out.hit         = 1'b0;
        n_out.nearest_out = r_pipe[DLY-1].nearest_in;
        n_out.face        = '0;
        for (int f = 0; f < NF; f++) begin
            if (face_ok[f] && (face_t[f] < n_out.nearest_out)) begin
                n_out.hit         = 1'b1;
                n_out.nearest_out = face_t[f];
                n_out.face        = 3'(f);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_vld[DLY-1];
        end
    end

    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule
